// ===== rtl/ps2md_pkg.sv =====
// Package for the PS/2 mouse packet decoder: register indexes, event kinds,
// packet flag bit positions, reset values and the emitter control struct.
// No dependencies.
`default_nettype none

package ps2md_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int BOUND_W         = 13;
    localparam int CFG_IDX_W       = 2;
    localparam int DELTA_W         = 11;
    localparam int NUM_BUTTONS     = 5;
    localparam int NUM_EVENTS      = 7;

    // Reset values of the bounds and of the pointer position.
    localparam logic [BOUND_W-1:0] BOUND_WIDTH_RESET  = 13'd1024;
    localparam logic [BOUND_W-1:0] BOUND_HEIGHT_RESET = 13'd768;
    localparam int POS_X_RESET = 512;
    localparam int POS_Y_RESET = 384;

    // Bit positions in the flag byte of a packet.
    localparam int FLAG_SYNC   = 3;
    localparam int FLAG_XSIGN  = 4;
    localparam int FLAG_YSIGN  = 5;
    localparam int FLAG_XOVF   = 6;
    localparam int FLAG_YOVF   = 7;

    // Bit positions in the fourth byte when side buttons are present.
    localparam int SIDE_BACK   = 4;
    localparam int SIDE_FWD    = 5;

    // Deltas of this magnitude or more are doubled.
    localparam logic signed [DELTA_W-1:0] BOOST_MIN = 11'sd16;

    // Positions in the pending event mask.
    localparam int EVB_WHEEL = 0;
    localparam int EVB_MOVE  = 1;
    localparam int EVB_BTN   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUND_WIDTH  = 2'd0,
        CFG_BOUND_HEIGHT = 2'd1,
        CFG_FOUR_BYTE    = 2'd2,
        CFG_SIDE_BUTTONS = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        EV_WHEEL = 2'd0,
        EV_MOVE  = 2'd1,
        EV_DOWN  = 2'd2,
        EV_UP    = 2'd3
    } t_event_kind;

    // What the emitter needs of one decoded packet, besides the position.
    typedef struct packed {
        logic signed [7:0]        wheel;
        logic [NUM_BUTTONS-1:0]   held;
        logic [NUM_EVENTS-1:0]    events;
    } t_evt_ctl;

endpackage

`default_nettype wire

// ===== rtl/ps2md_ifs.sv =====
// Handshake channels of the PS/2 mouse packet decoder: received bytes,
// configuration writes and output events. Depends on ps2md_pkg.
`default_nettype none

interface ps2md_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2md_cfg_if import ps2md_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BOUND_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface ps2md_evt_if import ps2md_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             event_kind;
    logic [COORD_WIDTH-1:0] pointer_x;
    logic [COORD_WIDTH-1:0] pointer_y;
    logic signed [7:0]      wheel_step;
    logic [NUM_BUTTONS-1:0] changed_button;
    logic [NUM_BUTTONS-1:0] button_mask;
    logic                   last_event;

    modport source (output valid, output event_kind, output pointer_x, output pointer_y,
                    output wheel_step, output changed_button, output button_mask,
                    output last_event, input ready);
    modport sink   (input valid, input event_kind, input pointer_x, input pointer_y,
                    input wheel_step, input changed_button, input button_mask,
                    input last_event, output ready);
endinterface

`default_nettype wire

// ===== rtl/ps2md_emitter.sv =====
// Event emitter: holds one decoded packet and sends its events through an output
// register, one word per cycle unless stalled. Needs ps2md_pkg and ps2md_evt_if.
`default_nettype none

module ps2md_emitter import ps2md_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [COORD_WIDTH-1:0] i_x,
    input  wire logic [COORD_WIDTH-1:0] i_y,
    input  wire t_evt_ctl               i_ctl,
    output logic                        o_free,
    ps2md_evt_if.source                 o_evt
);

    logic [NUM_EVENTS-1:0]  r_rem, n_rem;
    logic [COORD_WIDTH-1:0] r_x, r_y;
    logic signed [7:0]      r_wheel;
    logic [NUM_BUTTONS-1:0] r_held;

    logic                   r_ov, n_ov;
    t_event_kind            r_kind, n_kind;
    logic [COORD_WIDTH-1:0] r_ox, r_oy;
    logic signed [7:0]      r_ow, n_ow;
    logic [NUM_BUTTONS-1:0] r_ochg, n_ochg;
    logic [NUM_BUTTONS-1:0] r_omask;
    logic                   r_olast;

    logic                   can_emit, emit;
    logic [NUM_EVENTS-1:0]  pick, after;
    logic [NUM_BUTTONS-1:0] btn;

    // The lowest pending event goes out first: wheel, move, then buttons 0 to 4.
    always_comb begin
        pick     = r_rem & (~r_rem + NUM_EVENTS'(1));
        after    = r_rem & ~pick;
        can_emit = !r_ov || o_evt.ready;
        emit     = can_emit && (r_rem != '0);
        o_free   = (r_rem == '0) || (emit && (after == '0));
        btn      = pick[NUM_EVENTS-1:EVB_BTN];
    end

    always_comb begin
        n_kind = r_kind;
        n_ow   = r_ow;
        n_ochg = r_ochg;
        if (pick[EVB_WHEEL]) begin
            n_kind = EV_WHEEL;
            n_ow   = r_wheel;
            n_ochg = '0;
        end else if (pick[EVB_MOVE]) begin
            n_kind = EV_MOVE;
            n_ow   = '0;
            n_ochg = '0;
        end else begin
            n_kind = ((btn & r_held) != '0) ? EV_DOWN : EV_UP;
            n_ow   = '0;
            n_ochg = btn;
        end
    end

    always_comb begin
        n_rem = emit ? after : r_rem;
        if (i_load) begin
            n_rem = i_ctl.events;
        end
        if (emit) begin
            n_ov = 1'b1;
        end else if (o_evt.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_rem <= n_rem;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x     <= i_x;
            r_y     <= i_y;
            r_wheel <= i_ctl.wheel;
            r_held  <= i_ctl.held;
        end
        if (emit) begin
            r_kind  <= n_kind;
            r_ox    <= r_x;
            r_oy    <= r_y;
            r_ow    <= n_ow;
            r_ochg  <= n_ochg;
            r_omask <= r_held;
            r_olast <= (after == '0);
        end
    end

    assign o_evt.valid          = r_ov;
    assign o_evt.event_kind     = r_kind;
    assign o_evt.pointer_x      = r_ox;
    assign o_evt.pointer_y      = r_oy;
    assign o_evt.wheel_step     = r_ow;
    assign o_evt.changed_button = r_ochg;
    assign o_evt.button_mask    = r_omask;
    assign o_evt.last_event     = r_olast;

    // A new packet may only arrive once the previous one is fully sent.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("packet loaded while events still pending");

    a_button_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> $onehot0(r_ochg))
        else $error("changed button is not one-hot");

    a_wheel_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind == EV_WHEEL) |-> (r_ow != '0))
        else $error("wheel word with zero step");

    a_plain_no_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_kind == EV_WHEEL || r_kind == EV_MOVE)) |-> (r_ochg == '0))
        else $error("wheel or move word carries a button");

    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (after == '0)) |=> r_olast)
        else $error("final word of a packet not marked last");

endmodule

`default_nettype wire

// ===== rtl/ps2_mouse_packet_decoder.sv =====
// Top level of the PS/2 mouse packet decoder: byte input register, packet
// assembly, position and button update, and the event emitter.
// Depends on ps2md_pkg, ps2md_ifs and ps2md_emitter.
//
//  Port     Direction  Word                           Taken when
//  i_byte   in         rx_byte                        valid && ready
//  i_cfg    in         index, data (13 bits)          valid (ready is always high)
//  o_evt    out        kind, x, y, wheel, buttons     valid && ready
//
// A byte is taken into the input register every cycle that it is free or its byte
// moves on, and is decoded in the next. The byte that completes a packet waits
// there while the emitter still holds events of the previous packet; the emitter
// sends one word per cycle unless stalled, up to seven per packet. The first event
// leaves via the emitter's packet register and the output register. Reset is
// synchronous and takes effect at once; a stalled output register holds its word.
`default_nettype none

module ps2_mouse_packet_decoder import ps2md_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ps2md_byte_if.sink  i_byte,
    ps2md_cfg_if.sink   i_cfg,
    ps2md_evt_if.source o_evt
);

    localparam int CW = ((COORD_WIDTH > BOUND_W) ? COORD_WIDTH : BOUND_W) + 1;
    localparam int SW = ((COORD_WIDTH > DELTA_W) ? COORD_WIDTH : DELTA_W) + 2;
    localparam logic [COORD_WIDTH-1:0] COORD_MAX  = '1;
    localparam logic [COORD_WIDTH-1:0] POS_X_INIT = COORD_WIDTH'(POS_X_RESET);
    localparam logic [COORD_WIDTH-1:0] POS_Y_INIT = COORD_WIDTH'(POS_Y_RESET);

    function automatic logic [COORD_WIDTH-1:0] limit_of(input logic [BOUND_W-1:0] b);
        logic [CW-1:0] m1;
        m1 = CW'(b) - CW'(1);
        if (m1 > CW'(COORD_MAX)) begin
            return COORD_MAX;
        end
        return m1[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [COORD_WIDTH-1:0] clamp_coord(
        input logic signed [SW-1:0]  v,
        input logic [COORD_WIDTH-1:0] lim
    );
        logic signed [SW-1:0] le;
        le = signed'(SW'(lim));
        if (v < 0) begin
            return '0;
        end else if (v > le) begin
            return lim;
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [DELTA_W-1:0] boost(input logic signed [DELTA_W-1:0] d);
        if (d >= BOOST_MIN || d <= -BOOST_MIN) begin
            return d <<< 1;
        end
        return d;
    endfunction

    // Configuration.
    logic [BOUND_W-1:0]     r_bw, n_bw, r_bh, n_bh;
    logic                   r_four, n_four, r_side, n_side;
    // Packet state.
    logic                   r_bv, n_bv;
    logic [7:0]             r_b;
    logic [1:0]             r_idx, n_idx;
    logic [7:0]             r_pkt [0:2];
    logic [COORD_WIDTH-1:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [NUM_BUTTONS-1:0] r_held, n_held;

    logic                   cfg_we, clamp_sel;
    t_cfg_reg               cfg_reg;
    logic                   snap_free, complete, sync_miss, store, proceed, commit, ovf;
    logic [7:0]             flags, xb, yb, zb;
    logic signed [DELTA_W-1:0] dx, dy;
    logic signed [7:0]      z;
    logic [NUM_BUTTONS-1:0] held_new;
    logic [COORD_WIDTH-1:0] lim_x, lim_y;
    logic signed [SW-1:0]   src_x, src_y;
    logic [COORD_WIDTH-1:0] new_x, new_y;
    t_evt_ctl               ctl;
    logic                   load;

    // Configuration writes; a zero bound is ignored but still clamps.
    always_comb begin
        cfg_we    = i_cfg.valid;
        cfg_reg   = t_cfg_reg'(i_cfg.index);
        n_bw      = r_bw;
        n_bh      = r_bh;
        n_four    = r_four;
        n_side    = r_side;
        clamp_sel = 1'b0;
        if (cfg_we) begin
            case (cfg_reg)
                CFG_BOUND_WIDTH: begin
                    if (i_cfg.data != '0) n_bw = i_cfg.data;
                    clamp_sel = 1'b1;
                end
                CFG_BOUND_HEIGHT: begin
                    if (i_cfg.data != '0) n_bh = i_cfg.data;
                    clamp_sel = 1'b1;
                end
                CFG_FOUR_BYTE:    n_four = i_cfg.data[0];
                CFG_SIDE_BUTTONS: n_side = i_cfg.data[0];
                default:          ;
            endcase
        end
    end

    // Packet assembly and decode of the byte in the input register.
    always_comb begin
        sync_miss = (r_idx == 2'd0) && !r_b[FLAG_SYNC];
        complete  = r_four ? (r_idx == 2'd3) : (r_idx >= 2'd2);
        store     = !sync_miss && !complete;
        proceed   = r_bv && (!complete || snap_free);
        flags     = r_pkt[0];
        ovf       = flags[FLAG_XOVF] || flags[FLAG_YOVF];
        commit    = proceed && complete && !ovf;

        xb = r_pkt[1];
        yb = r_four ? r_pkt[2] : r_b;
        zb = r_b;

        dx = boost(DELTA_W'(signed'({flags[FLAG_XSIGN], xb})));
        dy = boost(-DELTA_W'(signed'({flags[FLAG_YSIGN], yb})));

        held_new = {2'b00, flags[2:0]};
        z        = '0;
        if (r_four) begin
            if (r_side) begin
                held_new[3] = zb[SIDE_BACK];
                held_new[4] = zb[SIDE_FWD];
                z = 8'(signed'(zb[3:0]));
            end else begin
                z = signed'(zb);
            end
        end

        ctl.wheel  = z;
        ctl.held   = held_new;
        ctl.events = {held_new ^ r_held, (dx != '0) || (dy != '0), z != '0};
        load       = commit && (ctl.events != '0);

        if (proceed) begin
            if (complete) begin
                n_idx = 2'd0;
            end else if (store) begin
                n_idx = r_idx + 2'd1;
            end else begin
                n_idx = r_idx;
            end
        end else begin
            n_idx = r_idx;
        end

        if (i_byte.valid && i_byte.ready) begin
            n_bv = 1'b1;
        end else if (proceed) begin
            n_bv = 1'b0;
        end else begin
            n_bv = r_bv;
        end
    end

    assign i_byte.ready = !r_bv || proceed;
    assign i_cfg.ready  = 1'b1;

    // One clamp per axis serves both a bound write and a packet move.
    always_comb begin
        lim_x = limit_of(n_bw);
        lim_y = limit_of(n_bh);
        if (clamp_sel) begin
            src_x = signed'(SW'(r_pos_x));
            src_y = signed'(SW'(r_pos_y));
        end else begin
            src_x = signed'(SW'(r_pos_x)) + SW'(dx);
            src_y = signed'(SW'(r_pos_y)) + SW'(dy);
        end
        new_x   = clamp_coord(src_x, lim_x);
        new_y   = clamp_coord(src_y, lim_y);
        n_pos_x = (clamp_sel || commit) ? new_x : r_pos_x;
        n_pos_y = (clamp_sel || commit) ? new_y : r_pos_y;
        n_held  = commit ? held_new : r_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw    <= BOUND_WIDTH_RESET;
            r_bh    <= BOUND_HEIGHT_RESET;
            r_four  <= 1'b0;
            r_side  <= 1'b0;
            r_bv    <= 1'b0;
            r_idx   <= 2'd0;
            r_pos_x <= POS_X_INIT;
            r_pos_y <= POS_Y_INIT;
            r_held  <= '0;
        end else begin
            r_bw    <= n_bw;
            r_bh    <= n_bh;
            r_four  <= n_four;
            r_side  <= n_side;
            r_bv    <= n_bv;
            r_idx   <= n_idx;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_b <= i_byte.rx_byte;
        end
        if (proceed && store) begin
            r_pkt[r_idx] <= r_b;
        end
    end

    ps2md_emitter #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_x     (n_pos_x),
        .i_y     (n_pos_y),
        .i_ctl   (ctl),
        .o_free  (snap_free),
        .o_evt   (o_evt)
    );

endmodule

`default_nettype wire

// ===== dv/tb_ps2_mouse_packet_decoder.sv =====
// Self-checking testbench for ps2_mouse_packet_decoder: feeds mouse bytes under random
// flow control, predicts every event word and compares it field by field on the output.
// Depends on ps2md_pkg, the ps2md channel interfaces and the decoder RTL.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder;
    import ps2md_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int CW            = COORD_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int STUCK_LIMIT   = 2000;

    typedef struct packed {
        t_event_kind            kind;
        logic [CW-1:0]          x;
        logic [CW-1:0]          y;
        logic [7:0]             wheel;
        logic [NUM_BUTTONS-1:0] changed;
        logic [NUM_BUTTONS-1:0] mask;
        logic                   last;
    } t_mouse_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ps2md_byte_if                              byte_ch ();
    ps2md_cfg_if                               cfg_ch ();
    ps2md_evt_if #(.COORD_WIDTH(COORD_WIDTH_DEF)) evt_ch ();

    ps2_mouse_packet_decoder #(.COORD_WIDTH(COORD_WIDTH_DEF)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .i_cfg   (cfg_ch),
        .o_evt   (evt_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Decoder state as the testbench sees it.
    int                     cfg_width = int'(BOUND_WIDTH_RESET);
    int                     cfg_height = int'(BOUND_HEIGHT_RESET);
    logic                   cfg_four = 1'b0;
    logic                   cfg_side = 1'b0;
    int                     asm_index = 0;
    logic [7:0]             asm_bytes [3] = '{8'h00, 8'h00, 8'h00};
    int                     pos_x = POS_X_RESET;
    int                     pos_y = POS_Y_RESET;
    logic [NUM_BUTTONS-1:0] held = '0;

    logic [7:0]   pending_bytes [$];
    t_mouse_word  predicted_events [$];

    int   mismatches = 0;
    int   bytes_taken = 0;
    int   packets_decoded = 0;
    int   packets_dropped = 0;
    int   events_checked = 0;
    int   cfg_writes = 0;

    logic no_idle = 1'b0;
    logic long_hold_req = 1'b0;
    logic long_hold_done = 1'b0;
    int   burst_left;
    int   gap_left;
    int   hold_left;
    int   pat_left;
    logic [31:0] stall_pat;
    logic [31:0] fresh_pat;
    int   stuck_cycles = 0;

    function automatic int clamp_coord(int v, int bound);
        int hi;
        hi = ((bound > (1 << CW)) ? (1 << CW) : bound) - 1;
        if (v < 0) v = 0;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic int boosted(int d);
        return (((d < 0) ? -d : d) >= int'(BOOST_MIN)) ? d * 2 : d;
    endfunction

    function automatic t_mouse_word make_event(t_event_kind kind, int wheel,
                                               logic [NUM_BUTTONS-1:0] btn);
        t_mouse_word e;
        e.kind    = kind;
        e.x       = pos_x[CW-1:0];
        e.y       = pos_y[CW-1:0];
        e.wheel   = wheel[7:0];
        e.changed = btn;
        e.mask    = held;
        e.last    = 1'b0;
        return e;
    endfunction

    task automatic clamp_pointer();
        pos_x = clamp_coord(pos_x, cfg_width);
        pos_y = clamp_coord(pos_y, cfg_height);
    endtask

    // Runs one accepted byte through packet assembly and queues the events it causes.
    task automatic decode_rx_byte(input logic [7:0] b);
        logic [7:0]             flags;
        logic [7:0]             xb;
        logic [7:0]             yb;
        logic [7:0]             zb;
        int                     dx;
        int                     dy;
        int                     z;
        int                     n;
        logic [NUM_BUTTONS-1:0] prev;
        logic [NUM_BUTTONS-1:0] flips;
        t_mouse_word            pkt_events [NUM_EVENTS];
        n = 0;
        z = 0;
        if (asm_index == 0 && !b[FLAG_SYNC]) begin
            // Out of sync: the byte is dropped.
        end else if (asm_index < (cfg_four ? 3 : 2)) begin
            asm_bytes[asm_index] = b;
            asm_index++;
        end else begin
            xb = asm_bytes[1];
            yb = cfg_four ? asm_bytes[2] : b;
            zb = cfg_four ? b : 8'h00;
            asm_index = 0;
            flags = asm_bytes[0];
            if (flags[FLAG_XOVF] || flags[FLAG_YOVF]) begin
                packets_dropped++;
            end else begin
                packets_decoded++;
                dx = flags[FLAG_XSIGN] ? int'(xb) - 256 : int'(xb);
                dy = flags[FLAG_YSIGN] ? int'(yb) - 256 : int'(yb);
                dx = boosted(dx);
                dy = boosted(-dy);
                pos_x += dx;
                pos_y += dy;
                clamp_pointer();
                prev = held;
                held = {2'b00, flags[2:0]};
                if (cfg_four) begin
                    if (cfg_side) begin
                        held[3] = zb[SIDE_BACK];
                        held[4] = zb[SIDE_FWD];
                        z = zb[3] ? int'(zb[3:0]) - 16 : int'(zb[3:0]);
                    end else begin
                        z = zb[7] ? int'(zb) - 256 : int'(zb);
                    end
                end
                if (z != 0) begin
                    pkt_events[n] = make_event(EV_WHEEL, z, '0);
                    n++;
                end
                if (dx != 0 || dy != 0) begin
                    pkt_events[n] = make_event(EV_MOVE, 0, '0);
                    n++;
                end
                flips = held ^ prev;
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    if (flips[i]) begin
                        pkt_events[n] = make_event(held[i] ? EV_DOWN : EV_UP, 0,
                                                   NUM_BUTTONS'(1 << i));
                        n++;
                    end
                end
                if (n > 0) pkt_events[n-1].last = 1'b1;
                for (int k = 0; k < n; k++) predicted_events.push_back(pkt_events[k]);
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_event();
        t_mouse_word want;
        if (predicted_events.size() == 0) begin
            $error("event word with none predicted: kind %0d at (%0d, %0d)",
                   evt_ch.event_kind, evt_ch.pointer_x, evt_ch.pointer_y);
            mismatches++;
        end else begin
            want = predicted_events.pop_front();
            events_checked++;
            check_field("event_kind", int'(want.kind), int'(evt_ch.event_kind));
            check_field("pointer_x", int'(want.x), int'(evt_ch.pointer_x));
            check_field("pointer_y", int'(want.y), int'(evt_ch.pointer_y));
            check_field("wheel_step", int'($signed(want.wheel)), int'(evt_ch.wheel_step));
            check_field("changed_button", int'(want.changed), int'(evt_ch.changed_button));
            check_field("button_mask", int'(want.mask), int'(evt_ch.button_mask));
            check_field("last_event", int'(want.last), int'(evt_ch.last_event));
        end
    endtask

    // Byte driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                decode_rx_byte(byte_ch.rx_byte);
                bytes_taken++;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (gap_left != 0 && !no_idle) begin
                    gap_left      <= gap_left - 1;
                    byte_ch.valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    byte_ch.valid   <= 1'b1;
                    byte_ch.rx_byte <= pending_bytes.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Event monitor: stalls on a random bit pattern, and once for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_ch.ready <= 1'b0;
            hold_left    <= 0;
            pat_left     <= 0;
        end else begin
            if (evt_ch.valid && evt_ch.ready) check_event();
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                evt_ch.ready <= 1'b0;
            end else if (long_hold_req && !long_hold_done) begin
                hold_left      <= LONG_HOLD;
                long_hold_done <= 1'b1;
                evt_ch.ready   <= 1'b0;
            end else if (no_idle) begin
                evt_ch.ready <= 1'b1;
            end else if (pat_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       fresh_pat = '1;
                    1:       fresh_pat = $urandom | $urandom;
                    2:       fresh_pat = $urandom;
                    default: fresh_pat = $urandom & $urandom;
                endcase
                evt_ch.ready <= fresh_pat[0];
                stall_pat    <= fresh_pat >> 1;
                pat_left     <= 31;
            end else begin
                evt_ch.ready <= stall_pat[0];
                stall_pat    <= stall_pat >> 1;
                pat_left     <= pat_left - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $error("no word moved on any channel for %0d cycles", STUCK_LIMIT);
            $display("FAIL ps2_mouse_packet_decoder");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Register writes go out only while the decoder is idle, so the model updates here.
    task automatic write_reg(input t_cfg_reg idx, input logic [BOUND_W-1:0] v);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_BOUND_WIDTH: begin
                if (v != 0) cfg_width = int'(v);
                clamp_pointer();
            end
            CFG_BOUND_HEIGHT: begin
                if (v != 0) cfg_height = int'(v);
                clamp_pointer();
            end
            CFG_FOUR_BYTE:    cfg_four = v[0];
            CFG_SIDE_BUTTONS: cfg_side = v[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || byte_ch.valid || predicted_events.size() != 0)
            @(posedge i_clk);
        // A byte that completes nothing may still sit in the input register.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_packet(input logic [7:0] flags, input logic [7:0] xb,
                                input logic [7:0] yb, input logic [7:0] zb);
        pending_bytes.push_back(flags);
        pending_bytes.push_back(xb);
        pending_bytes.push_back(yb);
        if (cfg_four) pending_bytes.push_back(zb);
    endtask

    // Pads an open packet with sync bytes so the next packet starts at byte zero.
    task automatic close_open_packet();
        if (asm_index != 0) begin
            repeat (((cfg_four ? 4 : 3) > asm_index) ? (cfg_four ? 4 : 3) - asm_index : 1)
                pending_bytes.push_back(8'h08);
            wait_drained();
        end
    endtask

    function automatic logic [7:0] random_delta();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'($urandom_range(0, 20));
            2:       return 8'(256 - $urandom_range(1, 20));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_wheel();
        return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    // Mostly whole packets with random content, plus stray bytes and cut-off packets.
    task automatic queue_random_traffic(input int n_items);
        int         pushed;
        int         style;
        int         len;
        int         cut;
        logic [7:0] flags;
        pushed = 0;
        while (pushed < n_items) begin
            style = $urandom_range(0, 99);
            len   = cfg_four ? 4 : 3;
            flags = 8'($urandom);
            flags[FLAG_SYNC] = 1'b1;
            if ($urandom_range(0, 9) != 0) begin
                flags[FLAG_XOVF] = 1'b0;
                flags[FLAG_YOVF] = 1'b0;
            end
            if (style < 82) begin
                queue_packet(flags, random_delta(), random_delta(), random_wheel());
                pushed += len;
            end else if (style < 92) begin
                pending_bytes.push_back(8'($urandom));
            end else begin
                cut = $urandom_range(1, len - 1);
                pending_bytes.push_back(flags);
                repeat (cut - 1) pending_bytes.push_back(8'($urandom));
                pushed += cut;
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_BOUND_WIDTH;
        cfg_ch.data     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Three-byte packets at the reset bounds: stray bytes, sign and size extremes,
        // boost threshold, overflow drops and a packet that changes nothing.
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hF7);
        queue_packet(8'h09, 8'h7F, 8'h01, 8'h00);
        queue_packet(8'h38, 8'h80, 8'hFF, 8'h00);
        queue_packet(8'h48, 8'h10, 8'h10, 8'h00);
        queue_packet(8'h8F, 8'h01, 8'h01, 8'h00);
        queue_packet(8'h08, 8'h00, 8'h00, 8'h00);
        queue_packet(8'h0F, 8'hF0, 8'h10, 8'h00);
        queue_packet(8'h3E, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // Zero bounds are ignored but still clamp; then the smallest screen.
        write_reg(CFG_BOUND_WIDTH, 13'd0);
        write_reg(CFG_BOUND_HEIGHT, 13'd0);
        write_reg(CFG_BOUND_WIDTH, 13'd1);
        write_reg(CFG_BOUND_HEIGHT, 13'd1);
        queue_random_traffic(30);

        // Oversized bounds, plain wheel byte.
        write_reg(CFG_BOUND_WIDTH, 13'h1FFF);
        write_reg(CFG_BOUND_HEIGHT, 13'd4096);
        write_reg(CFG_FOUR_BYTE, 13'd1);
        write_reg(CFG_SIDE_BUTTONS, 13'd0);
        close_open_packet();
        queue_packet(8'h08, 8'h00, 8'h00, 8'h80);
        queue_packet(8'h08, 8'h00, 8'h00, 8'h7F);
        queue_random_traffic(50);

        // Packet length changes while a packet is half assembled.
        close_open_packet();
        pending_bytes.push_back(8'h09);
        pending_bytes.push_back(8'h05);
        wait_drained();
        write_reg(CFG_FOUR_BYTE, 13'd0);
        pending_bytes.push_back(8'h07);
        wait_drained();
        write_reg(CFG_FOUR_BYTE, 13'd1);
        pending_bytes.push_back(8'h0A);
        pending_bytes.push_back(8'h03);
        pending_bytes.push_back(8'h04);
        wait_drained();
        write_reg(CFG_FOUR_BYTE, 13'd0);
        pending_bytes.push_back(8'h02);
        wait_drained();
        pending_bytes.push_back(8'h0C);
        pending_bytes.push_back(8'h11);
        wait_drained();
        write_reg(CFG_FOUR_BYTE, 13'd1);
        pending_bytes.push_back(8'h22);
        pending_bytes.push_back(8'h01);
        wait_drained();

        // Side buttons with a four-bit wheel on an odd-sized screen.
        write_reg(CFG_SIDE_BUTTONS, 13'd1);
        write_reg(CFG_BOUND_WIDTH, 13'd5000);
        write_reg(CFG_BOUND_HEIGHT, 13'd37);
        close_open_packet();
        queue_packet(8'h08, 8'h01, 8'h01, 8'h3F);
        queue_packet(8'h08, 8'h00, 8'h00, 8'h08);
        queue_random_traffic(50);

        // Side buttons enabled but three-byte packets: they must read as released.
        write_reg(CFG_FOUR_BYTE, 13'd0);
        write_reg(CFG_BOUND_WIDTH, 13'd640);
        write_reg(CFG_BOUND_HEIGHT, 13'd480);
        queue_random_traffic(50);

        // Back-to-back traffic while the event side holds off, so the input backs up.
        write_reg(CFG_FOUR_BYTE, 13'd1);
        write_reg(CFG_BOUND_WIDTH, 13'd1024);
        write_reg(CFG_BOUND_HEIGHT, 13'd768);
        no_idle       <= 1'b1;
        long_hold_req <= 1'b1;
        queue_random_traffic(50);
        no_idle <= 1'b0;

        write_reg(CFG_FOUR_BYTE, 13'd0);
        write_reg(CFG_SIDE_BUTTONS, 13'd0);
        write_reg(CFG_BOUND_WIDTH, 13'd4096);
        write_reg(CFG_BOUND_HEIGHT, 13'd1);
        queue_random_traffic(50);

        $display("Run covered %0d bytes: %0d packets decoded, %0d dropped on overflow.",
                 bytes_taken, packets_decoded, packets_dropped);
        $display("%0d event words checked across %0d register writes, %0d mismatches.",
                 events_checked, cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("PASS ps2_mouse_packet_decoder");
        end else begin
            $display("FAIL ps2_mouse_packet_decoder");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ps2md_pkg.sv
rtl/ps2md_ifs.sv
rtl/ps2md_emitter.sv
rtl/ps2_mouse_packet_decoder.sv
dv/tb_ps2_mouse_packet_decoder.sv
